@@ rtl/ihp_pkg.sv @@
// Shared types, widths and codes for the indexed min-heap.
package ihp_pkg;

   localparam int CAPACITY_DEFAULT = 256;
   localparam int ID_COUNT_DEFAULT = 1024;

   localparam int OP_W    = 2;
   localparam int ID_W    = 10;
   localparam int KEY_W   = 32;
   localparam int PAY_W   = 32;
   localparam int ST_W    = 3;
   localparam int CNT_W   = 9;
   localparam int LIMIT_W = 9;
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;
   localparam logic [PADDR_W-1:0] ADDR_LIMIT  = 3'd0;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_CHANGE = 2'd1,
      OP_DELMIN = 2'd2,
      OP_REMOVE = 2'd3
   } op_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_DUP       = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   typedef struct packed {
      logic [ID_W-1:0]         id;
      logic signed [KEY_W-1:0] key;
      logic [PAY_W-1:0]        payload;
   } entry_type;

   typedef enum logic [3:0] {
      CMD_NOP,
      CMD_CLEAR,
      CMD_LOAD,
      CMD_LOOKUP,
      CMD_CHANGE,
      CMD_TAKE,
      CMD_FILL,
      CMD_READ_PARENT,
      CMD_MOVE_UP,
      CMD_READ_LEFT,
      CMD_READ_RIGHT,
      CMD_MOVE_DOWN,
      CMD_PLACE,
      CMD_RESPOND
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            lookup_fail;
      logic            is_last;
      logic            hole_gt1;
      logic            cur_less_rd;
      logic            raise;
      logic            has_left;
      logic            child_less;
      logic            clear_done;
   } dp_status_type;

endpackage

@@ rtl/ihp_req_if.sv @@
// Request channel: one heap operation per transfer.
interface ihp_req_if;
   logic                        valid;
   logic                        ready;
   logic [ihp_pkg::OP_W-1:0]    operation;
   logic [ihp_pkg::ID_W-1:0]    item_id;
   logic signed [ihp_pkg::KEY_W-1:0] key;
   logic [ihp_pkg::PAY_W-1:0]   payload;

   modport source (output valid, operation, item_id, key, payload, input ready);
   modport sink   (input valid, operation, item_id, key, payload, output ready);
endinterface

@@ rtl/ihp_rsp_if.sv @@
// Response channel: one result per heap operation.
interface ihp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ihp_pkg::ST_W-1:0]    status;
   logic [ihp_pkg::ID_W-1:0]    out_id;
   logic signed [ihp_pkg::KEY_W-1:0] out_key;
   logic [ihp_pkg::PAY_W-1:0]   out_payload;
   logic [ihp_pkg::CNT_W-1:0]   entry_count;

   modport source (output valid, status, out_id, out_key, out_payload, entry_count,
                   input ready);
   modport sink   (input valid, status, out_id, out_key, out_payload, entry_count,
                   output ready);
endinterface

@@ rtl/ihp_datapath.sv @@
// Heap datapath: slot and position memories, working registers and compares.
module ihp_datapath #(
   parameter int CAPACITY = ihp_pkg::CAPACITY_DEFAULT,
   parameter int ID_COUNT = ihp_pkg::ID_COUNT_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ihp_pkg::cmd_type                cmd,
   output ihp_pkg::dp_status_type          st,
   input  logic [ihp_pkg::OP_W-1:0]        req_operation,
   input  logic [ihp_pkg::ID_W-1:0]        req_item_id,
   input  logic signed [ihp_pkg::KEY_W-1:0] req_key,
   input  logic [ihp_pkg::PAY_W-1:0]       req_payload,
   input  logic [ihp_pkg::LIMIT_W-1:0]     limit,
   output logic [ihp_pkg::ST_W-1:0]        rsp_status,
   output logic [ihp_pkg::ID_W-1:0]        rsp_out_id,
   output logic signed [ihp_pkg::KEY_W-1:0] rsp_out_key,
   output logic [ihp_pkg::PAY_W-1:0]       rsp_out_payload,
   output logic [ihp_pkg::CNT_W-1:0]       rsp_entry_count
);

   localparam int SW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(ID_COUNT);
   localparam int CW = (SW > ihp_pkg::LIMIT_W) ? SW + 1 : ihp_pkg::LIMIT_W + 1;

   ihp_pkg::entry_type slot_mem [0:CAPACITY];
   logic [SW-1:0]      pos_mem  [0:ID_COUNT-1];

   logic [ihp_pkg::OP_W-1:0]         op_ff;
   logic [ihp_pkg::ID_W-1:0]         id_ff;
   logic signed [ihp_pkg::KEY_W-1:0] key_ff;
   logic [ihp_pkg::PAY_W-1:0]        pay_ff;
   logic [SW-1:0]                    count_ff, count_in;
   logic [SW-1:0]                    hole_ff;
   logic [IW-1:0]                    clr_ff, clr_in;
   ihp_pkg::entry_type               cur_ff, left_ff, out_ff, slot_rd_ff;
   logic [SW-1:0]                    pos_rd_ff;
   logic [ihp_pkg::ST_W-1:0]         status_ff;

   logic               slot_re, slot_we, pos_re, pos_we;
   logic [SW-1:0]      slot_raddr, slot_waddr, pos_wdata;
   logic [IW-1:0]      pos_raddr, pos_waddr;
   ihp_pkg::entry_type slot_wdata, child;
   logic               id_ok, s_ok, full, has_right, pick_right;
   logic [SW:0]        left_idx, right_idx;
   logic [SW-1:0]      hole_par, child_idx;
   logic [CW-1:0]      lim_ext, cap_ext, eff_limit;
   logic [ihp_pkg::ST_W-1:0] lookup_status;

   always_comb begin
      id_ok     = 32'(id_ff) < ID_COUNT;
      s_ok      = id_ok && (pos_rd_ff != '0) && (pos_rd_ff <= count_ff);
      lim_ext   = CW'(limit);
      cap_ext   = CW'(CAPACITY);
      eff_limit = (lim_ext > cap_ext) ? cap_ext : lim_ext;
      full      = CW'(count_ff) >= eff_limit;
      case (op_ff)
         ihp_pkg::OP_INSERT: begin
            if (full) lookup_status = ihp_pkg::ST_FULL;
            else if (!id_ok) lookup_status = ihp_pkg::ST_NOT_FOUND;
            else if (s_ok) lookup_status = ihp_pkg::ST_DUP;
            else lookup_status = ihp_pkg::ST_OK;
         end
         ihp_pkg::OP_DELMIN: begin
            lookup_status = (count_ff == '0) ? ihp_pkg::ST_EMPTY : ihp_pkg::ST_OK;
         end
         default: begin
            lookup_status = s_ok ? ihp_pkg::ST_OK : ihp_pkg::ST_NOT_FOUND;
         end
      endcase
      hole_par   = hole_ff >> 1;
      left_idx   = {hole_ff, 1'b0};
      right_idx  = left_idx + 1'b1;
      has_right  = right_idx <= {1'b0, count_ff};
      // On equal keys the left child wins.
      pick_right = has_right && (slot_rd_ff.key < left_ff.key);
      child      = pick_right ? slot_rd_ff : left_ff;
      child_idx  = pick_right ? SW'(right_idx) : SW'(left_idx);
      count_in   = count_ff;
      clr_in     = clr_ff;
      case (cmd)
         ihp_pkg::CMD_CLEAR:  clr_in = clr_ff + 1'b1;
         ihp_pkg::CMD_LOOKUP: begin
            if (op_ff == ihp_pkg::OP_INSERT && lookup_status == ihp_pkg::ST_OK) begin
               count_in = count_ff + 1'b1;
            end
         end
         ihp_pkg::CMD_TAKE:   count_in = count_ff - 1'b1;
         default:             count_in = count_ff;
      endcase
   end

   always_comb begin
      st.op          = op_ff;
      st.lookup_fail = lookup_status != ihp_pkg::ST_OK;
      st.is_last     = hole_ff == count_ff;
      st.hole_gt1    = hole_ff > SW'(1);
      st.cur_less_rd = cur_ff.key < slot_rd_ff.key;
      st.raise       = slot_rd_ff.key < key_ff;
      st.has_left    = left_idx <= {1'b0, count_ff};
      st.child_less  = child.key < cur_ff.key;
      st.clear_done  = clr_ff == IW'(ID_COUNT - 1);
   end

   // Memory port steering.
   always_comb begin
      slot_re    = 1'b0;
      slot_raddr = hole_par;
      slot_we    = 1'b0;
      slot_waddr = hole_ff;
      slot_wdata = cur_ff;
      pos_re     = 1'b0;
      pos_raddr  = IW'(req_item_id);
      pos_we     = 1'b0;
      pos_waddr  = IW'(cur_ff.id);
      pos_wdata  = hole_ff;
      case (cmd)
         ihp_pkg::CMD_CLEAR: begin
            pos_we    = 1'b1;
            pos_waddr = clr_ff;
            pos_wdata = '0;
         end
         ihp_pkg::CMD_LOAD: pos_re = 1'b1;
         ihp_pkg::CMD_LOOKUP: begin
            slot_re    = 1'b1;
            slot_raddr = (op_ff == ihp_pkg::OP_DELMIN) ? SW'(1) : pos_rd_ff;
         end
         ihp_pkg::CMD_TAKE: begin
            pos_we     = 1'b1;
            pos_waddr  = IW'(slot_rd_ff.id);
            pos_wdata  = '0;
            slot_re    = 1'b1;
            slot_raddr = count_ff;
         end
         ihp_pkg::CMD_FILL, ihp_pkg::CMD_READ_PARENT: slot_re = 1'b1;
         ihp_pkg::CMD_MOVE_UP: begin
            slot_we    = 1'b1;
            slot_wdata = slot_rd_ff;
            pos_we     = 1'b1;
            pos_waddr  = IW'(slot_rd_ff.id);
         end
         ihp_pkg::CMD_READ_LEFT: begin
            slot_re    = 1'b1;
            slot_raddr = SW'(left_idx);
         end
         ihp_pkg::CMD_READ_RIGHT: begin
            slot_re    = has_right;
            slot_raddr = SW'(right_idx);
         end
         ihp_pkg::CMD_MOVE_DOWN: begin
            slot_we    = 1'b1;
            slot_wdata = child;
            pos_we     = 1'b1;
            pos_waddr  = IW'(child.id);
         end
         ihp_pkg::CMD_PLACE: begin
            slot_we = 1'b1;
            pos_we  = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
      if (slot_re) slot_rd_ff <= slot_mem[slot_raddr];
      if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
      if (pos_re) pos_rd_ff <= pos_mem[pos_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         clr_ff   <= '0;
      end else begin
         count_ff <= count_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd)
         ihp_pkg::CMD_LOAD: begin
            op_ff  <= req_operation;
            id_ff  <= req_item_id;
            key_ff <= req_key;
            pay_ff <= req_payload;
         end
         ihp_pkg::CMD_LOOKUP: begin
            status_ff <= lookup_status;
            out_ff    <= '0;
            if (op_ff == ihp_pkg::OP_INSERT) begin
               hole_ff <= count_ff + 1'b1;
            end else if (op_ff == ihp_pkg::OP_DELMIN) begin
               hole_ff <= SW'(1);
            end else begin
               hole_ff <= pos_rd_ff;
            end
            cur_ff.id      <= id_ff;
            cur_ff.key     <= key_ff;
            cur_ff.payload <= pay_ff;
         end
         ihp_pkg::CMD_CHANGE: begin
            cur_ff.id      <= slot_rd_ff.id;
            cur_ff.key     <= key_ff;
            cur_ff.payload <= slot_rd_ff.payload;
         end
         ihp_pkg::CMD_TAKE:       out_ff  <= slot_rd_ff;
         ihp_pkg::CMD_FILL:       cur_ff  <= slot_rd_ff;
         ihp_pkg::CMD_MOVE_UP:    hole_ff <= hole_par;
         ihp_pkg::CMD_READ_RIGHT: left_ff <= slot_rd_ff;
         ihp_pkg::CMD_MOVE_DOWN:  hole_ff <= child_idx;
         ihp_pkg::CMD_RESPOND: begin
            rsp_status      <= status_ff;
            rsp_out_id      <= out_ff.id;
            rsp_out_key     <= out_ff.key;
            rsp_out_payload <= out_ff.payload;
            rsp_entry_count <= ihp_pkg::CNT_W'(count_ff);
         end
         default: begin
         end
      endcase
   end

endmodule

@@ rtl/ihp_ctrl.sv @@
// Heap sequencer: steps the datapath through lookup, take-out and sift loops.
module ihp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  ihp_pkg::dp_status_type st,
   output ihp_pkg::cmd_type       cmd
);

   typedef enum logic [12:0] {
      S_CLEAR    = 13'b0000000000001,
      S_IDLE     = 13'b0000000000010,
      S_LOOKUP   = 13'b0000000000100,
      S_CHANGE   = 13'b0000000001000,
      S_TAKE     = 13'b0000000010000,
      S_FILL     = 13'b0000000100000,
      S_REPAIR   = 13'b0000001000000,
      S_UP_READ  = 13'b0000010000000,
      S_UP_CMP   = 13'b0000100000000,
      S_DN_LEFT  = 13'b0001000000000,
      S_DN_RIGHT = 13'b0010000000000,
      S_DN_CMP   = 13'b0100000000000,
      S_DONE     = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = ihp_pkg::CMD_NOP;
      case (state_ff)
         S_CLEAR: begin
            cmd = ihp_pkg::CMD_CLEAR;
            if (st.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd      = ihp_pkg::CMD_LOAD;
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            cmd = ihp_pkg::CMD_LOOKUP;
            if (st.lookup_fail) state_in = S_DONE;
            else if (st.op == ihp_pkg::OP_INSERT) state_in = S_UP_READ;
            else if (st.op == ihp_pkg::OP_CHANGE) state_in = S_CHANGE;
            else state_in = S_TAKE;
         end
         S_CHANGE: begin
            cmd      = ihp_pkg::CMD_CHANGE;
            state_in = st.raise ? S_DN_LEFT : S_UP_READ;
         end
         S_TAKE: begin
            // Taking out the last slot leaves no hole to fill.
            cmd      = ihp_pkg::CMD_TAKE;
            state_in = st.is_last ? S_DONE : S_FILL;
         end
         S_FILL: begin
            cmd      = ihp_pkg::CMD_FILL;
            state_in = st.hole_gt1 ? S_REPAIR : S_DN_LEFT;
         end
         S_REPAIR: begin
            if (st.cur_less_rd) begin
               cmd      = ihp_pkg::CMD_MOVE_UP;
               state_in = S_UP_READ;
            end else begin
               state_in = S_DN_LEFT;
            end
         end
         S_UP_READ: begin
            if (st.hole_gt1) begin
               cmd      = ihp_pkg::CMD_READ_PARENT;
               state_in = S_UP_CMP;
            end else begin
               cmd      = ihp_pkg::CMD_PLACE;
               state_in = S_DONE;
            end
         end
         S_UP_CMP: begin
            if (st.cur_less_rd) begin
               cmd      = ihp_pkg::CMD_MOVE_UP;
               state_in = S_UP_READ;
            end else begin
               cmd      = ihp_pkg::CMD_PLACE;
               state_in = S_DONE;
            end
         end
         S_DN_LEFT: begin
            if (st.has_left) begin
               cmd      = ihp_pkg::CMD_READ_LEFT;
               state_in = S_DN_RIGHT;
            end else begin
               cmd      = ihp_pkg::CMD_PLACE;
               state_in = S_DONE;
            end
         end
         S_DN_RIGHT: begin
            cmd      = ihp_pkg::CMD_READ_RIGHT;
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            if (st.child_less) begin
               cmd      = ihp_pkg::CMD_MOVE_DOWN;
               state_in = S_DN_LEFT;
            end else begin
               cmd      = ihp_pkg::CMD_PLACE;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd      = ihp_pkg::CMD_RESPOND;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || (cmd == ihp_pkg::CMD_RESPOND);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ rtl/indexed_min_heap.sv @@
// Indexed binary min-heap top level: channels, limit register, sequencer and datapath.
//
//   channel | direction | transfer when        | carries
//   req     | in        | valid && ready       | operation, item_id, key, payload
//   rsp     | out       | valid && ready       | status, out_id, out_key, out_payload, count
//   csr     | in (APB)  | psel/penable/pwrite  | capacity_limit at address 0
//
// Each level of a sift up is one read of the slot memory, a compare and a write; each level
// of a sift down is two reads, of the left and the right child, a compare and a write.
// After reset the position table is cleared one entry a cycle, with no request taken. A new
// request is taken while the previous result waits on rsp; the sequencer then holds the
// finished result until rsp is free.
module indexed_min_heap #(
   parameter int CAPACITY = ihp_pkg::CAPACITY_DEFAULT,
   parameter int ID_COUNT = ihp_pkg::ID_COUNT_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   ihp_req_if.sink                       req,
   ihp_rsp_if.source                     rsp,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [ihp_pkg::PADDR_W-1:0]   paddr,
   input  logic [ihp_pkg::PDATA_W-1:0]   pwdata,
   output logic [ihp_pkg::PDATA_W-1:0]   prdata,
   output logic                          pready
);

   logic [ihp_pkg::LIMIT_W-1:0] limit_ff, limit_in;
   ihp_pkg::cmd_type            cmd;
   ihp_pkg::dp_status_type      st;

   assign pready = 1'b1;
   assign prdata = (paddr == ihp_pkg::ADDR_LIMIT)
                   ? ihp_pkg::PDATA_W'(limit_ff) : '0;

   always_comb begin
      limit_in = limit_ff;
      if (psel && penable && pwrite && paddr == ihp_pkg::ADDR_LIMIT) begin
         limit_in = pwdata[ihp_pkg::LIMIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) limit_ff <= ihp_pkg::LIMIT_RESET;
      else limit_ff <= limit_in;
   end

   ihp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .st        (st),
      .cmd       (cmd)
   );

   ihp_datapath #(
      .CAPACITY (CAPACITY),
      .ID_COUNT (ID_COUNT)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .st              (st),
      .req_operation   (req.operation),
      .req_item_id     (req.item_id),
      .req_key         (req.key),
      .req_payload     (req.payload),
      .limit           (limit_ff),
      .rsp_status      (rsp.status),
      .rsp_out_id      (rsp.out_id),
      .rsp_out_key     (rsp.out_key),
      .rsp_out_payload (rsp.out_payload),
      .rsp_entry_count (rsp.entry_count)
   );

endmodule

@@ tb/tb_indexed_min_heap.sv @@
// Self-checking testbench for the indexed min-heap: directed table, random phases, predictor.
module tb_indexed_min_heap;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [ihp_pkg::KEY_W-1:0] key_type;

   typedef struct {
      ihp_pkg::status_type          status;
      logic [ihp_pkg::ID_W-1:0]     id;
      key_type                      key;
      logic [ihp_pkg::PAY_W-1:0]    payload;
      logic [ihp_pkg::CNT_W-1:0]    count;
   } outcome_type;

   typedef struct {
      ihp_pkg::op_type              op;
      logic [ihp_pkg::ID_W-1:0]     id;
      key_type                      key;
      logic [ihp_pkg::PAY_W-1:0]    payload;
      bit                           typed;
      outcome_type                  want;
   } step_row_type;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [ihp_pkg::PADDR_W-1:0] csr_paddr;
   logic [ihp_pkg::PDATA_W-1:0] csr_pwdata, csr_prdata;

   ihp_req_if req_ch();
   ihp_rsp_if rsp_ch();

   indexed_min_heap DUT (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .psel(csr_psel), .penable(csr_penable), .pwrite(csr_pwrite),
      .paddr(csr_paddr), .pwdata(csr_pwdata), .prdata(csr_prdata), .pready(csr_pready)
   );

   // Mirror of the heap contents.
   key_type                   heap_key [1:ihp_pkg::CAPACITY_DEFAULT];
   logic [ihp_pkg::ID_W-1:0]  heap_id  [1:ihp_pkg::CAPACITY_DEFAULT];
   logic [ihp_pkg::PAY_W-1:0] heap_pay [1:ihp_pkg::CAPACITY_DEFAULT];
   int                        slot_of  [0:ihp_pkg::ID_COUNT_DEFAULT-1];
   int                        held;
   int                        cap_limit;

   outcome_type pending_results[$];
   int          mismatches;
   int          idle_cycles;
   bit          steady_send;
   bit          steady_recv;
   bit          long_hold;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic put_slot(int s, logic [ihp_pkg::ID_W-1:0] id, key_type k,
                           logic [ihp_pkg::PAY_W-1:0] p);
      heap_id[s]  = id;
      heap_key[s] = k;
      heap_pay[s] = p;
      slot_of[id] = s;
   endtask

   task automatic swap_slots(int a, int b);
      logic [ihp_pkg::ID_W-1:0]  id;
      key_type                   k;
      logic [ihp_pkg::PAY_W-1:0] p;
      id = heap_id[a];
      k  = heap_key[a];
      p  = heap_pay[a];
      put_slot(a, heap_id[b], heap_key[b], heap_pay[b]);
      put_slot(b, id, k, p);
   endtask

   task automatic bubble_up(int s);
      while (s > 1 && heap_key[s] < heap_key[s/2]) begin
         swap_slots(s, s/2);
         s = s / 2;
      end
   endtask

   task automatic bubble_down(int s);
      int c;
      while (2*s <= held) begin
         c = 2*s;
         if (c + 1 <= held && heap_key[c+1] < heap_key[c]) c++;
         if (!(heap_key[c] < heap_key[s])) break;
         swap_slots(s, c);
         s = c;
      end
   endtask

   task automatic extract_slot(int s, inout outcome_type r);
      int last;
      last = held;
      r.id      = heap_id[s];
      r.key     = heap_key[s];
      r.payload = heap_pay[s];
      slot_of[heap_id[s]] = 0;
      if (s != last) put_slot(s, heap_id[last], heap_key[last], heap_pay[last]);
      held--;
      if (s <= held) begin
         if (s > 1 && heap_key[s] < heap_key[s/2]) bubble_up(s);
         else bubble_down(s);
      end
   endtask

   task automatic apply_heap_op(ihp_pkg::op_type op, logic [ihp_pkg::ID_W-1:0] id,
                                key_type k, logic [ihp_pkg::PAY_W-1:0] p,
                                output outcome_type r);
      int      s;
      int      lim;
      key_type old;
      r = '{ihp_pkg::ST_OK, '0, '0, '0, '0};
      lim = (cap_limit > ihp_pkg::CAPACITY_DEFAULT) ? ihp_pkg::CAPACITY_DEFAULT : cap_limit;
      s = 0;
      if (op != ihp_pkg::OP_DELMIN) begin
         s = slot_of[id];
         if (s > held) s = 0;
      end
      case (op)
         ihp_pkg::OP_INSERT: begin
            if (held >= lim) r.status = ihp_pkg::ST_FULL;
            else if (s != 0) r.status = ihp_pkg::ST_DUP;
            else begin
               held++;
               put_slot(held, id, k, p);
               bubble_up(held);
            end
         end
         ihp_pkg::OP_CHANGE: begin
            if (s == 0) r.status = ihp_pkg::ST_NOT_FOUND;
            else begin
               old = heap_key[s];
               heap_key[s] = k;
               if (old < k) bubble_down(s);
               else bubble_up(s);
            end
         end
         ihp_pkg::OP_DELMIN: begin
            if (held == 0) r.status = ihp_pkg::ST_EMPTY;
            else extract_slot(1, r);
         end
         default: begin
            if (s == 0) r.status = ihp_pkg::ST_NOT_FOUND;
            else extract_slot(s, r);
         end
      endcase
      r.count = held[ihp_pkg::CNT_W-1:0];
   endtask

   task automatic write_limit(int value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ihp_pkg::ADDR_LIMIT;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      cap_limit = value & 'h1FF;
   endtask

   // Drives one operation; after its transfer, unless steady_send, it may pause.
   task automatic issue(step_row_type row);
      outcome_type r;
      req_ch.valid     <= 1'b1;
      req_ch.operation <= row.op;
      req_ch.item_id   <= row.id;
      req_ch.key       <= row.key;
      req_ch.payload   <= row.payload;
      do @(posedge clock); while (!req_ch.ready);
      apply_heap_op(row.op, row.id, row.key, row.payload, r);
      pending_results.push_back(row.typed ? row.want : r);
      if (!steady_send && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic random_phase(int limit, int items, int insert_pct, int id_span);
      step_row_type row;
      int           pick;
      write_limit(limit);
      steady_send = ($urandom_range(0, 2) == 0);
      steady_recv = ($urandom_range(0, 2) == 0);
      repeat (items) begin
         pick = $urandom_range(0, 99);
         row.typed = 1'b0;
         if (pick < insert_pct) row.op = ihp_pkg::OP_INSERT;
         else row.op = ihp_pkg::op_type'($urandom_range(1, 3));
         if ($urandom_range(0, 9) == 0)
            row.id = ihp_pkg::ID_W'($urandom_range(0, ihp_pkg::ID_COUNT_DEFAULT-1));
         else
            row.id = ihp_pkg::ID_W'($urandom_range(0, id_span));
         case ($urandom_range(0, 2))
            0: row.key = $signed($urandom_range(0, 15)) - 8;
            1: row.key = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: row.key = $urandom;
         endcase
         row.payload = $urandom;
         issue(row);
      end
      drain();
   endtask

   // Receiver: always ready or a random stall pattern, with one long hold-off when asked.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         if (long_hold) begin
            rsp_ch.ready <= 1'b0;
            repeat (400) @(posedge clock);
            long_hold = 1'b0;
         end else if (steady_recv) begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result transfer: status %0d",
                                           rsp_ch.status);
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.status !== want.status || rsp_ch.out_id !== want.id ||
                rsp_ch.out_key !== want.key || rsp_ch.out_payload !== want.payload ||
                rsp_ch.entry_count !== want.count) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("Mismatch: expected st %0d id %0d key %0d pay %h cnt %0d",
                           want.status, want.id, want.key, want.payload, want.count);
                  $display("          got      st %0d id %0d key %0d pay %h cnt %0d",
                           rsp_ch.status, rsp_ch.out_id, rsp_ch.out_key,
                           rsp_ch.out_payload, rsp_ch.entry_count);
               end
            end
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= 6000) begin
         $display("Verification failed");
         $finish;
      end
   end

   step_row_type directed[$];

   function automatic step_row_type mk(ihp_pkg::op_type op, int id, key_type k,
                                       logic [ihp_pkg::PAY_W-1:0] p);
      mk = '{op, ihp_pkg::ID_W'(id), k, p, 1'b0,
             '{ihp_pkg::ST_OK, '0, '0, '0, '0}};
   endfunction

   function automatic step_row_type mk_typed(ihp_pkg::op_type op, int id, key_type k,
                                             logic [ihp_pkg::PAY_W-1:0] p,
                                             ihp_pkg::status_type st, int oid, key_type ok,
                                             logic [ihp_pkg::PAY_W-1:0] op_pay, int cnt);
      mk_typed = '{op, ihp_pkg::ID_W'(id), k, p, 1'b1,
                   '{st, ihp_pkg::ID_W'(oid), ok, op_pay, ihp_pkg::CNT_W'(cnt)}};
   endfunction

   initial begin
      reset       <= 1'b1;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      req_ch.valid     <= 1'b0;
      req_ch.operation <= ihp_pkg::OP_INSERT;
      req_ch.item_id   <= '0;
      req_ch.key       <= '0;
      req_ch.payload   <= '0;
      mismatches  = 0;
      idle_cycles = 0;
      held        = 0;
      cap_limit   = ihp_pkg::LIMIT_RESET;
      long_hold   = 1'b0;
      steady_send = 1'b1;
      steady_recv = 1'b1;
      foreach (slot_of[i]) slot_of[i] = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Empty heap, extremes of every field, ties and all three kinds of key change.
      directed.push_back(mk_typed(ihp_pkg::OP_DELMIN, 0, 0, 0,
                                  ihp_pkg::ST_EMPTY, 0, 0, 0, 0));
      directed.push_back(mk_typed(ihp_pkg::OP_REMOVE, 5, 0, 0,
                                  ihp_pkg::ST_NOT_FOUND, 0, 0, 0, 0));
      directed.push_back(mk_typed(ihp_pkg::OP_CHANGE, 1023, 0, 0,
                                  ihp_pkg::ST_NOT_FOUND, 0, 0, 0, 0));
      directed.push_back(mk_typed(ihp_pkg::OP_INSERT, 0, 32'sh80000000, '1,
                                  ihp_pkg::ST_OK, 0, 0, 0, 1));
      directed.push_back(mk_typed(ihp_pkg::OP_INSERT, 1023, 32'sh7FFFFFFF, 0,
                                  ihp_pkg::ST_OK, 0, 0, 0, 2));
      directed.push_back(mk_typed(ihp_pkg::OP_INSERT, 0, 5, 7,
                                  ihp_pkg::ST_DUP, 0, 0, 0, 2));
      directed.push_back(mk(ihp_pkg::OP_INSERT, 7, 0, 32'h1234));
      directed.push_back(mk(ihp_pkg::OP_INSERT, 8, 0, 32'h5678));
      directed.push_back(mk(ihp_pkg::OP_INSERT, 9, 0, 32'hAAAA5555));
      directed.push_back(mk(ihp_pkg::OP_CHANGE, 1023, -5, '1));
      directed.push_back(mk(ihp_pkg::OP_CHANGE, 7, 100, 0));
      directed.push_back(mk(ihp_pkg::OP_CHANGE, 8, 0, 0));
      directed.push_back(mk(ihp_pkg::OP_CHANGE, 0, 32'sh7FFFFFFF, 0));
      directed.push_back(mk(ihp_pkg::OP_REMOVE, 1023, 32'sh7FFFFFFF, '1));
      directed.push_back(mk(ihp_pkg::OP_REMOVE, 9, 0, 0));
      directed.push_back(mk(ihp_pkg::OP_DELMIN, 1023, -1, '1));
      directed.push_back(mk(ihp_pkg::OP_DELMIN, 0, 0, 0));
      directed.push_back(mk(ihp_pkg::OP_DELMIN, 0, 0, 0));
      directed.push_back(mk_typed(ihp_pkg::OP_DELMIN, 0, 0, 0,
                                  ihp_pkg::ST_EMPTY, 0, 0, 0, 0));

      write_limit(ihp_pkg::CAPACITY_DEFAULT);
      foreach (directed[i]) issue(directed[i]);
      drain();

      // Limit of one: full is reported ahead of a duplicate id.
      write_limit(1);
      issue(mk_typed(ihp_pkg::OP_INSERT, 3, 1, 2, ihp_pkg::ST_OK, 0, 0, 0, 1));
      issue(mk_typed(ihp_pkg::OP_INSERT, 3, 1, 2, ihp_pkg::ST_FULL, 0, 0, 0, 1));
      issue(mk_typed(ihp_pkg::OP_INSERT, 4, 1, 2, ihp_pkg::ST_FULL, 0, 0, 0, 1));
      drain();

      random_phase(ihp_pkg::CAPACITY_DEFAULT, 150, 45, 31);
      random_phase(1, 60, 50, 3);
      random_phase(0, 40, 50, 7);
      // Fill to the full size while the receiver holds off.
      long_hold = 1'b1;
      random_phase(511, 330, 85, 1023);
      random_phase(3, 100, 50, 7);
      random_phase(ihp_pkg::CAPACITY_DEFAULT, 300, 30, 63);

      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

@@ files.f @@
rtl/ihp_pkg.sv
rtl/ihp_req_if.sv
rtl/ihp_rsp_if.sv
rtl/ihp_datapath.sv
rtl/ihp_ctrl.sv
rtl/indexed_min_heap.sv
tb/tb_indexed_min_heap.sv
